[hdl/opl_pkg.sv]
// shared types, register codes and reset values for the lookahead velocity block
// no dependencies
package opl_pkg;

    localparam int unsigned CFG_W  = 31;
    localparam int unsigned DATA_W = 32;

    localparam logic [CFG_W-1:0] LOOKAHEAD_RST     = 31'd26214;
    localparam logic [CFG_W-1:0] TARGET_SPEED_RST  = 31'd13107;
    localparam logic [CFG_W-1:0] MAX_TURN_RATE_RST = 31'd65536;
    localparam logic [CFG_W-1:0] DEADBAND_RST      = 31'd1311;

    localparam logic [1:0] REG_LOOKAHEAD     = 2'd0;
    localparam logic [1:0] REG_TARGET_SPEED  = 2'd1;
    localparam logic [1:0] REG_MAX_TURN_RATE = 2'd2;
    localparam logic [1:0] REG_DEADBAND      = 2'd3;

    localparam logic [2:0] MUL_SQ_X  = 3'd0;
    localparam logic [2:0] MUL_SQ_Y  = 3'd1;
    localparam logic [2:0] MUL_SQ_L  = 3'd2;
    localparam logic [2:0] MUL_SQ_CX = 3'd3;
    localparam logic [2:0] MUL_SQ_CY = 3'd4;
    localparam logic [2:0] MUL_TS_CX = 3'd5;
    localparam logic [2:0] MUL_TS_CY = 3'd6;

    typedef struct packed {
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic                     last_point;
    } point_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] turn_rate;
    } vel_t;

    typedef struct packed {
        logic [CFG_W-1:0] lookahead;
        logic [CFG_W-1:0] target_speed;
        logic [CFG_W-1:0] max_turn_rate;
        logic [CFG_W-1:0] deadband;
    } cfg_t;

    typedef struct packed {
        logic       load_pt;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       test;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       store_vx;
        logic       emit_move;
        logic       emit_turn;
    } dp_cmd_t;

    typedef struct packed {
        logic found;
        logic last;
        logic outside;
        logic out_busy;
    } dp_status_t;

endpackage

[hdl/omni_pursuit_lookahead_velocity_core.sv]
// top level of the lookahead velocity block
// depends on opl_pkg, opl_regs, opl_ctrl, opl_dp
//
// path points in the robot frame arrive on the point channel (valid/ready),
// one transaction per point, the final point of a path marked by last_point.
// the first point at or beyond the lookahead distance is kept, else the
// final point. on the final point one velocity command leaves on the vel
// channel (valid/ready).
// a point is taken as soon as it is offered once a target is held; else three
// products through the shared multiplier and a compare precede the next point.
// when the kept point lies inside the deadband a turn command follows, else a
// move command after the norm, the bit-per-cycle square root and the two
// bit-per-cycle divisions, one per axis.
// the output register holds a finished command while the receiver stalls;
// new points are still taken until the next command is due.
// reset clears the held target and loads the register defaults; the
// configuration port is apb with registers at byte offsets 0, 4, 8 and 12.
module omni_pursuit_lookahead_velocity_core
    import opl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    output logic        point_ready,
    input  point_t      point_data,
    output logic        vel_valid,
    input  logic        vel_ready,
    output vel_t        vel_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    opl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    opl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_last  (point_data.last_point),
        .point_ready (point_ready),
        .status      (status),
        .cmd         (cmd)
    );

    opl_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .point_data (point_data),
        .cmd        (cmd),
        .status     (status),
        .vel_valid  (vel_valid),
        .vel_ready  (vel_ready),
        .vel_data   (vel_data)
    );

endmodule

[hdl/opl_regs.sv]
// apb configuration registers: lookahead, speed, turn rate, deadband
// depends on opl_pkg
module opl_regs
    import opl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lookahead     <= LOOKAHEAD_RST;
            cfg_reg.target_speed  <= TARGET_SPEED_RST;
            cfg_reg.max_turn_rate <= MAX_TURN_RATE_RST;
            cfg_reg.deadband      <= DEADBAND_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_LOOKAHEAD:     cfg_reg.lookahead     <= pwdata[CFG_W-1:0];
                REG_TARGET_SPEED:  cfg_reg.target_speed  <= pwdata[CFG_W-1:0];
                REG_MAX_TURN_RATE: cfg_reg.max_turn_rate <= pwdata[CFG_W-1:0];
                REG_DEADBAND:      cfg_reg.deadband      <= pwdata[CFG_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LOOKAHEAD:     prdata = {1'b0, cfg_reg.lookahead};
            REG_TARGET_SPEED:  prdata = {1'b0, cfg_reg.target_speed};
            REG_MAX_TURN_RATE: prdata = {1'b0, cfg_reg.max_turn_rate};
            REG_DEADBAND:      prdata = {1'b0, cfg_reg.deadband};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

[hdl/opl_ctrl.sv]
// sequencer for point test, square root, division and result hand-off
// depends on opl_pkg
module opl_ctrl
    import opl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       point_valid,
    input  logic       point_last,
    output logic       point_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SQX       = 5'd1;
    localparam logic [4:0] S_SQY       = 5'd2;
    localparam logic [4:0] S_SQL       = 5'd3;
    localparam logic [4:0] S_TEST      = 5'd4;
    localparam logic [4:0] S_DB        = 5'd5;
    localparam logic [4:0] S_NX        = 5'd6;
    localparam logic [4:0] S_NY        = 5'd7;
    localparam logic [4:0] S_NSUM      = 5'd8;
    localparam logic [4:0] S_SQRT_INIT = 5'd9;
    localparam logic [4:0] S_SQRT      = 5'd10;
    localparam logic [4:0] S_MX        = 5'd11;
    localparam logic [4:0] S_DIVX_INIT = 5'd12;
    localparam logic [4:0] S_DIVX      = 5'd13;
    localparam logic [4:0] S_STX       = 5'd14;
    localparam logic [4:0] S_MY        = 5'd15;
    localparam logic [4:0] S_DIVY_INIT = 5'd16;
    localparam logic [4:0] S_DIVY      = 5'd17;
    localparam logic [4:0] S_EMIT_MOVE = 5'd18;
    localparam logic [4:0] S_EMIT_TURN = 5'd19;

    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd63;

    logic [4:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    assign point_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_SQ_X;
        unique case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    cmd.load_pt = 1'b1;
                    if (!status.found)
                        state_next = S_SQX;
                    else if (point_last)
                        state_next = S_DB;
                end
            end
            S_SQX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ_X;
                state_next  = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_SQ_Y;
                cmd.acc_load = 1'b1;
                state_next   = S_SQL;
            end
            S_SQL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ_L;
                cmd.acc_add = 1'b1;
                state_next  = S_TEST;
            end
            S_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = status.last ? S_DB : S_IDLE;
            end
            S_DB:
                state_next = status.outside ? S_NX : S_EMIT_TURN;
            S_NX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ_CX;
                state_next  = S_NY;
            end
            S_NY:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_SQ_CY;
                cmd.acc_load = 1'b1;
                state_next   = S_NSUM;
            end
            S_NSUM:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_SQRT_INIT;
            end
            S_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                    state_next = S_MX;
            end
            S_MX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TS_CX;
                state_next  = S_DIVX_INIT;
            end
            S_DIVX_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIVX;
            end
            S_DIVX:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_STX;
            end
            S_STX:
            begin
                cmd.store_vx = 1'b1;
                state_next   = S_MY;
            end
            S_MY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TS_CY;
                state_next  = S_DIVY_INIT;
            end
            S_DIVY_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIVY;
            end
            S_DIVY:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_EMIT_MOVE;
            end
            S_EMIT_MOVE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_move = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_TURN:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_turn = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

[hdl/opl_dp.sv]
// datapath: point registers, shared multiplier, square root and divider units,
// output register; depends on opl_pkg
module opl_dp
    import opl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  point_t     point_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       vel_valid,
    input  logic       vel_ready,
    output vel_t       vel_data
);

    logic signed [DATA_W-1:0] px_reg, py_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] cx_reg, cy_reg;
    logic                     found_reg;

    logic [DATA_W-1:0]   mul_a, mul_b;
    logic [2*DATA_W-1:0] prod_reg, acc_reg;

    logic [2*DATA_W-1:0] rad_reg;
    logic [DATA_W+2:0]   srem_reg, srem_shift, srem_trial;
    logic [DATA_W-1:0]   root_reg;
    logic                sqrt_ge;

    logic [2*DATA_W-1:0] num_reg;
    logic [DATA_W:0]     drem_reg, drem_shift;
    logic [DATA_W-1:0]   quo_reg, divisor;
    logic                div_ge;

    logic signed [DATA_W-1:0] vx_reg, vx_next, vy_next;
    vel_t out_reg;
    logic out_valid_reg;

    logic [DATA_W-1:0] mag_px, mag_py, mag_cx, mag_cy;

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    assign mag_px = mag(px_reg);
    assign mag_py = mag(py_reg);
    assign mag_cx = mag(cx_reg);
    assign mag_cy = mag(cy_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SQ_X:
            begin
                mul_a = mag_px;
                mul_b = mag_px;
            end
            MUL_SQ_Y:
            begin
                mul_a = mag_py;
                mul_b = mag_py;
            end
            MUL_SQ_L:
            begin
                mul_a = {1'b0, cfg.lookahead};
                mul_b = {1'b0, cfg.lookahead};
            end
            MUL_SQ_CX:
            begin
                mul_a = mag_cx;
                mul_b = mag_cx;
            end
            MUL_SQ_CY:
            begin
                mul_a = mag_cy;
                mul_b = mag_cy;
            end
            MUL_TS_CX:
            begin
                mul_a = {1'b0, cfg.target_speed};
                mul_b = mag_cx;
            end
            MUL_TS_CY:
            begin
                mul_a = {1'b0, cfg.target_speed};
                mul_b = mag_cy;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one result bit per step
    assign srem_shift = {srem_reg[DATA_W:0], rad_reg[2*DATA_W-1 -: 2]};
    assign srem_trial = {1'b0, root_reg, 2'b01};
    assign sqrt_ge    = (srem_shift >= srem_trial);

    assign divisor    = (root_reg == '0) ? DATA_W'(1) : root_reg;
    assign drem_shift = {drem_reg[DATA_W-1:0], num_reg[2*DATA_W-1]};
    assign div_ge     = (drem_shift >= {1'b0, divisor});

    assign vx_next = cx_reg[DATA_W-1] ? -$signed(quo_reg) : $signed(quo_reg);
    assign vy_next = cy_reg[DATA_W-1] ? -$signed(quo_reg) : $signed(quo_reg);

    assign status.found    = found_reg;
    assign status.last     = last_reg;
    assign status.outside  = (mag_cx > {1'b0, cfg.deadband}) || (mag_cy > {1'b0, cfg.deadband});
    assign status.out_busy = out_valid_reg && !vel_ready;

    assign vel_valid = out_valid_reg;
    assign vel_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.test)
            begin
                found_reg <= (acc_reg >= prod_reg);
                cx_reg    <= px_reg;
                cy_reg    <= py_reg;
            end
            else if (cmd.emit_move || cmd.emit_turn)
            begin
                found_reg <= 1'b0;
                cx_reg    <= '0;
                cy_reg    <= '0;
            end
            if (cmd.emit_move || cmd.emit_turn)
                out_valid_reg <= 1'b1;
            else if (vel_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pt)
        begin
            px_reg   <= point_data.point_x;
            py_reg   <= point_data.point_y;
            last_reg <= point_data.last_point;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.acc_load)
            acc_reg <= prod_reg;
        else if (cmd.acc_add)
            acc_reg <= acc_reg + prod_reg;

        if (cmd.sqrt_init)
        begin
            rad_reg  <= acc_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[2*DATA_W-3:0], 2'b00};
            if (sqrt_ge)
            begin
                srem_reg <= srem_shift - srem_trial;
                root_reg <= {root_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_shift;
                root_reg <= {root_reg[DATA_W-2:0], 1'b0};
            end
        end

        if (cmd.div_init)
        begin
            num_reg  <= prod_reg + {{(DATA_W+1){1'b0}}, divisor[DATA_W-1:1]};
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[2*DATA_W-2:0], 1'b0};
            if (div_ge)
            begin
                drem_reg <= drem_shift - {1'b0, divisor};
                quo_reg  <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= drem_shift;
                quo_reg  <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end

        if (cmd.store_vx)
            vx_reg <= vx_next;

        if (cmd.emit_move)
        begin
            out_reg.vel_x     <= vx_reg;
            out_reg.vel_y     <= vy_next;
            out_reg.turn_rate <= '0;
        end
        else if (cmd.emit_turn)
        begin
            out_reg.vel_x     <= '0;
            out_reg.vel_y     <= '0;
            out_reg.turn_rate <= $signed({1'b0, cfg.max_turn_rate});
        end
    end

endmodule

[hdl/opl_checker.sv]
// port-level checks on the lookahead velocity block, bound to the top level
// depends on opl_pkg and omni_pursuit_lookahead_velocity_core
module opl_checker
    import opl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        vel_valid,
    input logic        vel_ready,
    input vel_t        vel_data
);

    a_vel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vel_valid && !vel_ready |=> vel_valid)
        else $error("vel transaction dropped while stalled");

    a_vel_stable: assert property (@(posedge clk) disable iff (!rst_n)
        vel_valid && !vel_ready |=> $stable(vel_data))
        else $error("vel payload changed while stalled");

    a_turn_excl: assert property (@(posedge clk) disable iff (!rst_n)
        vel_valid && (vel_data.turn_rate != 0) |->
            (vel_data.vel_x == 0) && (vel_data.vel_y == 0))
        else $error("turning while driving");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        vel_valid |-> !vel_data.turn_rate[DATA_W-1]
            && (vel_data.vel_x != 32'sh8000_0000)
            && (vel_data.vel_y != 32'sh8000_0000))
        else $error("velocity beyond speed range");

endmodule

bind omni_pursuit_lookahead_velocity_core opl_checker u_opl_checker (.*);
